>>> hw/rtl/psdp_pkg.sv
// ----------------------------------------------------------------------------
// psdp_pkg: shared types and tables of the datagram parser
// Parse phase codes, the parser state record, the per-byte result record and
// the per-message-type field layout tables.
// ----------------------------------------------------------------------------
package psdp_pkg;

  // Parse phase codes.
  localparam logic [2:0] PhChan   = 3'd0;
  localparam logic [2:0] PhType   = 3'd1;
  localparam logic [2:0] PhField  = 3'd2;
  localparam logic [2:0] PhRest   = 3'd3;
  localparam logic [2:0] PhOpt    = 3'd4;
  localparam logic [2:0] PhOptLen = 3'd5;
  localparam logic [2:0] PhOptVal = 3'd6;

  // Field role codes used by the parser itself.
  localparam logic [3:0] RoleChan     = 4'd0;
  localparam logic [3:0] RoleType     = 4'd1;
  localparam logic [3:0] RoleOptCode  = 4'd3;
  localparam logic [3:0] RoleOptValue = 4'd4;
  localparam logic [3:0] RoleNone     = 4'd15;

  // Handshake option codes with special handling.
  localparam logic [7:0] OptSwarmId    = 8'd2;
  localparam logic [7:0] OptAddrMethod = 8'd6;
  localparam logic [7:0] OptLiveWindow = 8'd7;
  localparam logic [7:0] OptSuppMsgs   = 8'd8;
  localparam logic [7:0] OptChunkSize  = 8'd9;
  localparam logic [7:0] OptEnd        = 8'hff;

  localparam logic [7:0] MsgHandshake = 8'd0;
  localparam logic [7:0] MsgLastKnown = 8'd13;
  localparam logic [7:0] AddrDefault  = 8'd2;

  // Parser state carried from byte to byte.
  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  hdr_seen;
    logic [7:0]  cur_type;
    logic [3:0]  cur_role;
    logic [15:0] bytes_left;
    logic [15:0] field_idx;
    logic [7:0]  opt_held;
    logic [7:0]  addr_method;
    logic [7:0]  len_high;
  } st_t;

  localparam st_t StReset = '{
    phase:       PhChan,
    hdr_seen:    3'd0,
    cur_type:    8'd0,
    cur_role:    4'd0,
    bytes_left:  16'd4,
    field_idx:   16'd0,
    opt_held:    8'd0,
    addr_method: AddrDefault,
    len_high:    8'd0
  };

  // Result produced for every payload byte.
  typedef struct packed {
    logic [3:0]  field_role;
    logic [7:0]  type_code;
    logic [15:0] byte_in_field;
    logic        message_start;
    logic        keep_alive;
    logic        truncated;
    logic        last_result;
  } res_t;

  // Role of field k of message type t (types 0..13).
  function automatic logic [3:0] seq_role(logic [7:0] t, logic [1:0] k);
    logic [15:0] row;
    case (t)
      8'd0:              row = 16'hfff2;
      8'd1, 8'd7:        row = 16'h8765;
      8'd2:              row = 16'hf765;
      8'd3, 8'd8, 8'd9:  row = 16'hff65;
      8'd4:              row = 16'hf965;
      8'd5:              row = 16'hffba;
      8'd12:             row = 16'hffbc;
      8'd13:             row = 16'hffed;
      default:           row = 16'hffff;
    endcase
    return row[{k, 2'b00} +: 4];
  endfunction

  // Length of field k of message type t; zero means it runs to the end.
  function automatic logic [4:0] seq_len(logic [7:0] t, logic [1:0] k);
    logic [19:0] row;
    case (t)
      8'd0:                    row = {5'd0, 5'd0, 5'd0, 5'd4};
      8'd1, 8'd2, 8'd7:        row = {5'd0, 5'd8, 5'd4, 5'd4};
      8'd3, 8'd8, 8'd9:        row = {5'd0, 5'd0, 5'd4, 5'd4};
      8'd4:                    row = {5'd0, 5'd20, 5'd4, 5'd4};
      8'd5:                    row = {5'd0, 5'd0, 5'd2, 5'd4};
      8'd12:                   row = {5'd0, 5'd0, 5'd2, 5'd16};
      8'd13:                   row = {5'd0, 5'd0, 5'd0, 5'd2};
      default:                 row = 20'd0;
    endcase
    return row[5 * k +: 5];
  endfunction

  // Saturating increment of a field index.
  function automatic logic [15:0] sat_inc(logic [15:0] x);
    return (x == 16'hffff) ? x : x + 16'd1;
  endfunction

  // Start field k of the current message, or expect a type byte if none.
  function automatic st_t begin_field(st_t s, logic [2:0] k);
    st_t        n;
    logic [3:0] r;
    logic [4:0] len;
    n   = s;
    r   = seq_role(s.cur_type, k[1:0]);
    len = seq_len(s.cur_type, k[1:0]);
    if (k > 3'd3 || s.cur_type > MsgLastKnown || r == RoleNone) begin
      n.phase = PhType;
    end else begin
      n.cur_role  = r;
      n.field_idx = 16'd0;
      if (len == 5'd0) begin
        n.phase = PhRest;
      end else begin
        n.phase      = PhField;
        n.bytes_left = {11'd0, len};
      end
    end
    return n;
  endfunction

  // Move on to the field after the current one; a handshake goes on to its options.
  function automatic st_t advance_field(st_t s);
    st_t        n;
    logic       found;
    logic [2:0] nk;
    n     = s;
    found = 1'b0;
    nk    = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (!found && seq_role(s.cur_type, k[1:0]) == s.cur_role) begin
        found = 1'b1;
        nk    = 3'(k + 1);
      end
    end
    if (s.cur_type == MsgHandshake) begin
      n.phase = PhOpt;
    end else if (s.cur_type > MsgLastKnown || !found) begin
      n.phase = PhType;
    end else begin
      n = begin_field(s, nk);
    end
    return n;
  endfunction

  // Start the value bytes of an option of the given length.
  function automatic st_t start_value(st_t s, logic [15:0] len);
    st_t n;
    n           = s;
    n.field_idx = 16'd0;
    if (len == 16'd0) begin
      n.phase = PhOpt;
    end else begin
      n.phase      = PhOptVal;
      n.bytes_left = len;
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/peer_streaming_datagram_parser_unit.sv
// ----------------------------------------------------------------------------
// peer_streaming_datagram_parser_unit: datagram byte role tagger
// Pipeline: input register, then psdp_step, then the result register.
// Throughput: one byte per cycle while the receiver takes results; the per-byte
// state update in psdp_step is one short pass between input and result register.
// Reset: rst_ni clears both stages and returns the parser to the start of a
// datagram; the parser also returns there after every last byte.
// ----------------------------------------------------------------------------
module peer_streaming_datagram_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [3:0] field_role, [11:4] type_code,
                                        // [27:12] byte_in_field, [28] message_start,
                                        // [29] keep_alive, [30] truncated, [31] zero
  output logic        m_axis_tlast_o
);

  logic           in_vld_q;
  logic [7:0]     in_byte_q;
  logic           in_last_q;
  logic           out_vld_q;
  psdp_pkg::res_t out_res_q;
  psdp_pkg::st_t  st_q;
  psdp_pkg::st_t  st_d;
  psdp_pkg::res_t res_d;
  logic           out_free;
  logic           advance;
  logic           in_take;

  // Pipeline handshake: the input stage moves when the result stage frees up.
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Per-byte parse logic.
  psdp_step u_step (
    .st_i        (st_q),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .st_o        (st_d),
    .res_o       (res_d)
  );

  // Control state: stage valids and parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= psdp_pkg::StReset;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  // Result request packing.
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_res_q.truncated, out_res_q.keep_alive,
                            out_res_q.message_start, out_res_q.byte_in_field,
                            out_res_q.type_code, out_res_q.field_role};
  assign m_axis_tlast_o  = out_res_q.last_result;

endmodule

>>> hw/rtl/psdp_step.sv
// ----------------------------------------------------------------------------
// psdp_step: per-byte parse logic
// Labels one payload byte from the current parser state and computes the
// state that the next byte sees.
// ----------------------------------------------------------------------------
module psdp_step (
  input  psdp_pkg::st_t  st_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output psdp_pkg::st_t  st_o,
  output psdp_pkg::res_t res_o
);

  psdp_pkg::st_t  st;
  psdp_pkg::res_t res;

  // Role, index and next state for this byte.
  always_comb begin
    st                = st_i;
    res.field_role    = psdp_pkg::RoleNone;
    res.type_code     = st_i.cur_type;
    res.byte_in_field = 16'd0;
    res.message_start = 1'b0;
    res.keep_alive    = 1'b0;
    res.truncated     = 1'b0;
    res.last_result   = last_byte_i;

    case (st_i.phase)
      psdp_pkg::PhChan: begin
        res.field_role    = psdp_pkg::RoleChan;
        res.type_code     = 8'd0;
        res.byte_in_field = {13'd0, st_i.hdr_seen};
        st.hdr_seen       = st_i.hdr_seen + 3'd1;
        if (st.hdr_seen >= 3'd4) begin
          st.phase       = psdp_pkg::PhType;
          res.keep_alive = last_byte_i;
        end
      end
      psdp_pkg::PhType: begin
        res.field_role    = psdp_pkg::RoleType;
        res.type_code     = data_byte_i;
        res.message_start = 1'b1;
        st.cur_type       = data_byte_i;
        st.cur_role       = psdp_pkg::RoleType;
        if (data_byte_i == psdp_pkg::MsgHandshake) begin
          st.addr_method = psdp_pkg::AddrDefault;
        end
        st = psdp_pkg::begin_field(st, 3'd0);
      end
      psdp_pkg::PhField: begin
        res.field_role    = st_i.cur_role;
        res.byte_in_field = st_i.field_idx;
        st.field_idx      = psdp_pkg::sat_inc(st_i.field_idx);
        if (st_i.bytes_left <= 16'd1) begin
          st = psdp_pkg::advance_field(st);
        end else begin
          st.bytes_left = st_i.bytes_left - 16'd1;
        end
      end
      psdp_pkg::PhRest: begin
        res.field_role    = st_i.cur_role;
        res.byte_in_field = st_i.field_idx;
        st.field_idx      = psdp_pkg::sat_inc(st_i.field_idx);
      end
      psdp_pkg::PhOpt: begin
        res.field_role = psdp_pkg::RoleOptCode;
        st.opt_held    = data_byte_i;
        st.field_idx   = 16'd0;
        if (data_byte_i == psdp_pkg::OptEnd) begin
          st.phase = psdp_pkg::PhType;
        end else if (data_byte_i <= 8'd1 ||
                     (data_byte_i >= 8'd3 && data_byte_i <= psdp_pkg::OptAddrMethod)) begin
          st = psdp_pkg::start_value(st, 16'd1);
        end else if (data_byte_i == psdp_pkg::OptSwarmId) begin
          st.phase      = psdp_pkg::PhOptLen;
          st.bytes_left = 16'd2;
        end else if (data_byte_i == psdp_pkg::OptSuppMsgs) begin
          st.phase      = psdp_pkg::PhOptLen;
          st.bytes_left = 16'd1;
        end else if (data_byte_i == psdp_pkg::OptLiveWindow) begin
          if (st_i.addr_method == 8'd0 || st_i.addr_method == 8'd2) begin
            st = psdp_pkg::start_value(st, 16'd4);
          end else begin
            st = psdp_pkg::start_value(st, 16'd8);
          end
        end else if (data_byte_i == psdp_pkg::OptChunkSize) begin
          st = psdp_pkg::start_value(st, 16'd4);
        end
      end
      psdp_pkg::PhOptLen: begin
        res.field_role    = psdp_pkg::RoleOptValue;
        res.byte_in_field = st_i.field_idx;
        st.field_idx      = psdp_pkg::sat_inc(st_i.field_idx);
        if (st_i.bytes_left >= 16'd2) begin
          st.len_high   = data_byte_i;
          st.bytes_left = 16'd1;
        end else if (st_i.opt_held == psdp_pkg::OptSwarmId) begin
          st = psdp_pkg::start_value(st, {st_i.len_high, data_byte_i});
        end else begin
          st = psdp_pkg::start_value(st, {8'd0, data_byte_i});
        end
      end
      psdp_pkg::PhOptVal: begin
        res.field_role    = psdp_pkg::RoleOptValue;
        res.byte_in_field = st_i.field_idx;
        st.field_idx      = psdp_pkg::sat_inc(st_i.field_idx);
        if (st_i.opt_held == psdp_pkg::OptAddrMethod) begin
          st.addr_method = data_byte_i;
        end
        if (st_i.bytes_left <= 16'd1) begin
          st.phase = psdp_pkg::PhOpt;
        end else begin
          st.bytes_left = st_i.bytes_left - 16'd1;
        end
      end
      default: begin
        st.phase = psdp_pkg::PhType;
      end
    endcase

    // End of datagram: report truncation and return to the reset state.
    if (last_byte_i) begin
      res.truncated = !(st.phase == psdp_pkg::PhType || st.phase == psdp_pkg::PhRest);
      st            = psdp_pkg::StReset;
    end
  end

  assign st_o  = st;
  assign res_o = res;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the datagram byte role tagger
// Streams whole datagrams into the parser, one payload byte per request, and
// predicts the role record of every byte in step with the accepted input. Each
// result request is compared field by field with the oldest prediction. Both
// stream sides idle at random, the receiver once holds off long enough to back
// up the input, and the sender waits for the output to drain midway and at the end.
// ----------------------------------------------------------------------------
module testbench;

  // Message type codes.
  localparam logic [7:0] MsgData      = 8'd1;
  localparam logic [7:0] MsgAck       = 8'd2;
  localparam logic [7:0] MsgHave      = 8'd3;
  localparam logic [7:0] MsgIntegrity = 8'd4;
  localparam logic [7:0] MsgPexV4     = 8'd5;
  localparam logic [7:0] MsgPexReq    = 8'd6;
  localparam logic [7:0] MsgSigned    = 8'd7;
  localparam logic [7:0] MsgRequest   = 8'd8;
  localparam logic [7:0] MsgCancel    = 8'd9;
  localparam logic [7:0] MsgChoke     = 8'd10;
  localparam logic [7:0] MsgUnchoke   = 8'd11;
  localparam logic [7:0] MsgPexV6     = 8'd12;
  localparam logic [7:0] MsgPexCert   = 8'd13;
  localparam logic [7:0] MsgUnknownLo = 8'd14;
  localparam logic [7:0] MsgUnknownHi = 8'hff;

  // Field roles not named by the package.
  localparam logic [3:0] RoleHsChan   = 4'd2;
  localparam logic [3:0] RoleStart    = 4'd5;
  localparam logic [3:0] RoleEnd      = 4'd6;
  localparam logic [3:0] RoleStamp    = 4'd7;
  localparam logic [3:0] RoleBody     = 4'd8;
  localparam logic [3:0] RoleHash     = 4'd9;
  localparam logic [3:0] RoleIpv4     = 4'd10;
  localparam logic [3:0] RolePort     = 4'd11;
  localparam logic [3:0] RoleIpv6     = 4'd12;
  localparam logic [3:0] RoleCertSize = 4'd13;
  localparam logic [3:0] RoleCert     = 4'd14;

  // Handshake option codes with a single value byte, and the unknown range.
  localparam logic [7:0] OptVersion    = 8'd0;
  localparam logic [7:0] OptMinVersion = 8'd1;
  localparam logic [7:0] OptIntegrity  = 8'd3;
  localparam logic [7:0] OptSigAlgo    = 8'd4;
  localparam logic [7:0] OptMerkleFn   = 8'd5;
  localparam logic [7:0] OptUnknownLo  = 8'h0a;
  localparam logic [7:0] OptUnknownHi  = 8'hfe;

  // Chunk addressing methods that use a 4-byte live window.
  localparam logic [7:0] AddrBins32 = 8'd0;

  // One field of a message layout; a zero length runs to the end.
  typedef struct packed {
    logic [3:0] role;
    logic [4:0] len;
  } slot_t;

  // Layout of field k of a message type.
  function automatic slot_t field_layout(logic [7:0] kind, int k);
    logic [3:0] roles [4];
    int         lens  [4];
    slot_t      s;
    roles = '{psdp_pkg::RoleNone, psdp_pkg::RoleNone, psdp_pkg::RoleNone,
              psdp_pkg::RoleNone};
    lens  = '{0, 0, 0, 0};
    case (kind)
      psdp_pkg::MsgHandshake: begin
        roles[0] = RoleHsChan;
        lens[0]  = 4;
      end
      MsgData, MsgSigned: begin
        roles = '{RoleStart, RoleEnd, RoleStamp, RoleBody};
        lens  = '{4, 4, 8, 0};
      end
      MsgAck: begin
        roles = '{RoleStart, RoleEnd, RoleStamp, psdp_pkg::RoleNone};
        lens  = '{4, 4, 8, 0};
      end
      MsgHave, MsgRequest, MsgCancel: begin
        roles = '{RoleStart, RoleEnd, psdp_pkg::RoleNone, psdp_pkg::RoleNone};
        lens  = '{4, 4, 0, 0};
      end
      MsgIntegrity: begin
        roles = '{RoleStart, RoleEnd, RoleHash, psdp_pkg::RoleNone};
        lens  = '{4, 4, 20, 0};
      end
      MsgPexV4: begin
        roles = '{RoleIpv4, RolePort, psdp_pkg::RoleNone, psdp_pkg::RoleNone};
        lens  = '{4, 2, 0, 0};
      end
      MsgPexV6: begin
        roles = '{RoleIpv6, RolePort, psdp_pkg::RoleNone, psdp_pkg::RoleNone};
        lens  = '{16, 2, 0, 0};
      end
      MsgPexCert: begin
        roles = '{RoleCertSize, RoleCert, psdp_pkg::RoleNone, psdp_pkg::RoleNone};
        lens  = '{2, 0, 0, 0};
      end
      default: ;
    endcase
    s.role = psdp_pkg::RoleNone;
    s.len  = '0;
    if (k >= 0 && k < 4) begin
      s.role = roles[k];
      s.len  = 5'(lens[k]);
    end
    return s;
  endfunction

  // Role predictor and store of expected role records.
  class tag_scoreboard;
    logic [2:0]     phase;
    logic [2:0]     chan_seen;
    logic [7:0]     msg_type;
    logic [3:0]     cur_role;
    logic [15:0]    remaining;
    logic [15:0]    field_idx;
    logic [7:0]     opt_held;
    logic [7:0]     addr_method;
    logic [7:0]     len_high;
    psdp_pkg::res_t expected_tags[$];
    int             requests = 0;
    int             results = 0;
    int             mismatches = 0;
    int             datagrams = 0;
    int             ends_truncated = 0;
    int             ends_keep_alive = 0;

    function new();
      restart();
    endfunction

    // Back to the start of a datagram.
    function void restart();
      phase       = psdp_pkg::PhChan;
      chan_seen   = 3'd0;
      msg_type    = 8'd0;
      cur_role    = psdp_pkg::RoleChan;
      remaining   = 16'd4;
      field_idx   = 16'd0;
      opt_held    = 8'd0;
      addr_method = psdp_pkg::AddrDefault;
      len_high    = 8'd0;
    endfunction

    function void bump_index();
      if (field_idx != 16'hffff) field_idx++;
    endfunction

    // Enter field k of the current message, or wait for a type byte.
    function void open_field(int k);
      slot_t s;
      s = field_layout(msg_type, k);
      if (msg_type > psdp_pkg::MsgLastKnown || s.role == psdp_pkg::RoleNone) begin
        phase = psdp_pkg::PhType;
        return;
      end
      cur_role  = s.role;
      field_idx = 16'd0;
      if (s.len == 0) begin
        phase = psdp_pkg::PhRest;
      end else begin
        phase     = psdp_pkg::PhField;
        remaining = 16'(s.len);
      end
    endfunction

    // A fixed field is done; handshakes go on to their option list.
    function void next_field();
      slot_t s;
      if (msg_type == psdp_pkg::MsgHandshake) begin
        phase = psdp_pkg::PhOpt;
        return;
      end
      for (int k = 0; k < 4; k++) begin
        s = field_layout(msg_type, k);
        if (s.role == cur_role) begin
          open_field(k + 1);
          return;
        end
      end
      phase = psdp_pkg::PhType;
    endfunction

    function void open_value(logic [15:0] len);
      field_idx = 16'd0;
      if (len == 16'd0) begin
        phase = psdp_pkg::PhOpt;
      end else begin
        phase     = psdp_pkg::PhOptVal;
        remaining = len;
      end
    endfunction

    // Role record of one payload byte, with the parser state moved on.
    function psdp_pkg::res_t tag_byte(logic [7:0] value, logic last);
      psdp_pkg::res_t r;
      r = '0;
      r.field_role  = psdp_pkg::RoleNone;
      r.type_code   = msg_type;
      r.last_result = last;
      case (phase)
        psdp_pkg::PhChan: begin
          r.field_role    = psdp_pkg::RoleChan;
          r.type_code     = 8'd0;
          r.byte_in_field = 16'(chan_seen);
          chan_seen++;
          if (chan_seen >= 3'd4) begin
            phase        = psdp_pkg::PhType;
            r.keep_alive = last;
          end
        end
        psdp_pkg::PhType: begin
          r.field_role    = psdp_pkg::RoleType;
          r.type_code     = value;
          r.message_start = 1'b1;
          msg_type        = value;
          cur_role        = psdp_pkg::RoleType;
          if (value == psdp_pkg::MsgHandshake) addr_method = psdp_pkg::AddrDefault;
          open_field(0);
        end
        psdp_pkg::PhField: begin
          r.field_role    = cur_role;
          r.byte_in_field = field_idx;
          bump_index();
          if (remaining <= 16'd1) next_field();
          else remaining--;
        end
        psdp_pkg::PhRest: begin
          r.field_role    = cur_role;
          r.byte_in_field = field_idx;
          bump_index();
        end
        psdp_pkg::PhOpt: begin
          r.field_role = psdp_pkg::RoleOptCode;
          opt_held     = value;
          field_idx    = 16'd0;
          if (value == psdp_pkg::OptEnd) begin
            phase = psdp_pkg::PhType;
          end else if (value == OptVersion || value == OptMinVersion ||
                       value == OptIntegrity || value == OptSigAlgo ||
                       value == OptMerkleFn || value == psdp_pkg::OptAddrMethod) begin
            open_value(16'd1);
          end else if (value == psdp_pkg::OptSwarmId) begin
            phase     = psdp_pkg::PhOptLen;
            remaining = 16'd2;
          end else if (value == psdp_pkg::OptSuppMsgs) begin
            phase     = psdp_pkg::PhOptLen;
            remaining = 16'd1;
          end else if (value == psdp_pkg::OptLiveWindow) begin
            if (addr_method == AddrBins32 || addr_method == psdp_pkg::AddrDefault)
              open_value(16'd4);
            else open_value(16'd8);
          end else if (value == psdp_pkg::OptChunkSize) begin
            open_value(16'd4);
          end
        end
        psdp_pkg::PhOptLen: begin
          r.field_role    = psdp_pkg::RoleOptValue;
          r.byte_in_field = field_idx;
          bump_index();
          if (remaining >= 16'd2) begin
            len_high  = value;
            remaining = 16'd1;
          end else if (opt_held == psdp_pkg::OptSwarmId) begin
            open_value({len_high, value});
          end else begin
            open_value({8'd0, value});
          end
        end
        psdp_pkg::PhOptVal: begin
          r.field_role    = psdp_pkg::RoleOptValue;
          r.byte_in_field = field_idx;
          bump_index();
          if (opt_held == psdp_pkg::OptAddrMethod) addr_method = value;
          if (remaining <= 16'd1) phase = psdp_pkg::PhOpt;
          else remaining--;
        end
        default: phase = psdp_pkg::PhType;
      endcase
      if (last) begin
        r.truncated = !(phase == psdp_pkg::PhType || phase == psdp_pkg::PhRest);
        restart();
      end
      return r;
    endfunction

    // An input request was accepted.
    function void note_request(logic [7:0] value, logic last);
      psdp_pkg::res_t r;
      r = tag_byte(value, last);
      expected_tags.push_back(r);
      requests++;
      if (last) datagrams++;
      if (r.truncated) ends_truncated++;
      if (r.keep_alive) ends_keep_alive++;
    endfunction

    function void flag(string what, psdp_pkg::res_t want, logic [31:0] got,
                       logic got_last);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s (expected/actual): role %0d/%0d type %h/%h idx %0d/%0d",
                 $time, what, want.field_role, got[3:0], want.type_code, got[11:4],
                 want.byte_in_field, got[27:12]);
        $display("    start %b/%b keep %b/%b trunc %b/%b last %b/%b pad 0/%b",
                 want.message_start, got[28], want.keep_alive, got[29],
                 want.truncated, got[30], want.last_result, got_last, got[31]);
      end
    endfunction

    // A result request was accepted.
    function void check_result(logic [31:0] got, logic got_last);
      psdp_pkg::res_t want;
      results++;
      if (expected_tags.size() == 0) begin
        flag("result with nothing expected", '0, got, got_last);
        return;
      end
      want = expected_tags.pop_front();
      if (got[3:0] !== want.field_role || got[11:4] !== want.type_code ||
          got[27:12] !== want.byte_in_field || got[28] !== want.message_start ||
          got[29] !== want.keep_alive || got[30] !== want.truncated ||
          got[31] !== 1'b0 || got_last !== want.last_result)
        flag("role mismatch", want, got, got_last);
    endfunction

    function int pending();
      return expected_tags.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;   // [7:0] data_byte
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;          // [3:0] role, [11:4] type, [27:12] index,
                                        // [28] start, [29] keep-alive, [30] truncated
  logic        m_axis_tlast_o;

  tag_scoreboard sb = new();
  logic [7:0]    dgram[$];
  bit            steady = 1'b0;
  int            holds_asked = 0;

  peer_streaming_datagram_parser_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #(64'd10_000_000);
    $display("FAILURE");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off when asked.
  initial begin : sink
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // Output values are stable at the falling edge, ahead of the accepting edge.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
  end

  // Datagram builders.
  task automatic add_bytes(input int n);
    repeat (n) dgram.push_back(8'($urandom));
  endtask

  task automatic add_fill(input int n, input logic [7:0] value);
    repeat (n) dgram.push_back(value);
  endtask

  task automatic add_opt_byte(input logic [7:0] code, input logic [7:0] value);
    dgram.push_back(code);
    dgram.push_back(value);
  endtask

  task automatic add_opt_fixed(input logic [7:0] code, input int n);
    dgram.push_back(code);
    add_bytes(n);
  endtask

  // Options with a length prefix: two bytes for the swarm id, else one.
  task automatic add_opt_list(input logic [7:0] code, input logic [15:0] len);
    dgram.push_back(code);
    if (code == psdp_pkg::OptSwarmId) dgram.push_back(len[15:8]);
    dgram.push_back(len[7:0]);
    add_bytes(int'(len));
  endtask

  // Type byte and fixed fields; an open-ended field gets body_len bytes.
  task automatic add_message(input logic [7:0] kind, input int body_len, output bit to_end);
    slot_t s;
    to_end = 1'b0;
    dgram.push_back(kind);
    for (int k = 0; k < 4; k++) begin
      s = field_layout(kind, k);
      if (s.role == psdp_pkg::RoleNone) break;
      if (s.len == 0) begin
        add_bytes(body_len);
        to_end = 1'b1;
        break;
      end
      add_bytes(int'(s.len));
    end
  endtask

  // A random handshake option list, closed by the end code.
  task automatic add_random_options();
    logic [7:0] method;
    logic [7:0] value;
    method = psdp_pkg::AddrDefault;
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 11))
        0: add_opt_byte(OptVersion, 8'($urandom));
        1: add_opt_byte(OptMinVersion, 8'($urandom));
        2: add_opt_byte(OptIntegrity, 8'($urandom));
        3: add_opt_byte(OptSigAlgo, 8'($urandom));
        4: add_opt_byte(OptMerkleFn, 8'($urandom));
        5: begin
          value  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
          method = value;
          add_opt_byte(psdp_pkg::OptAddrMethod, value);
        end
        6: begin
          if ($urandom_range(0, 99) == 0)
            add_opt_list(psdp_pkg::OptSwarmId, 16'($urandom_range(256, 300)));
          else
            add_opt_list(psdp_pkg::OptSwarmId, 16'($urandom_range(0, 6)));
        end
        7: add_opt_list(psdp_pkg::OptSuppMsgs, 16'($urandom_range(0, 6)));
        8: begin
          if (method == AddrBins32 || method == psdp_pkg::AddrDefault)
            add_opt_fixed(psdp_pkg::OptLiveWindow, 4);
          else add_opt_fixed(psdp_pkg::OptLiveWindow, 8);
        end
        9: add_opt_fixed(psdp_pkg::OptChunkSize, 4);
        default: add_opt_fixed(8'($urandom_range(OptUnknownLo, OptUnknownHi)), 0);
      endcase
    end
    dgram.push_back(psdp_pkg::OptEnd);
  endtask

  // Mostly well-formed datagrams, some noise, some cut short.
  task automatic build_random_dgram();
    logic [7:0] kind;
    int         pick;
    int         keep;
    bit         to_end;
    dgram.delete();
    if ($urandom_range(0, 99) < 8) begin
      add_bytes($urandom_range(1, 24));
      return;
    end
    add_bytes(4);
    to_end = 1'b0;
    repeat ($urandom_range(0, 4)) begin
      if (!to_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) kind = psdp_pkg::MsgHandshake;
        else if (pick < 90) kind = 8'($urandom_range(MsgData, MsgPexCert));
        else kind = 8'($urandom_range(MsgUnknownLo, MsgUnknownHi));
        add_message(kind, $urandom_range(0, 12), to_end);
        if (kind == psdp_pkg::MsgHandshake) add_random_options();
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      keep = $urandom_range(1, dgram.size());
      while (dgram.size() > keep) void'(dgram.pop_back());
    end
  endtask

  // Offer one byte and wait until it is accepted.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while (!steady && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tlast_i  <= is_last;
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    sb.note_request(value, is_last);
    @(posedge clk_i);
  endtask

  task automatic send_dgram();
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1);
  endtask

  // Stop offering and wait until every expected result has come.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int base;
    bit to_end;
    bit held;
    bit drained;
    held    = 1'b0;
    drained = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Keep-alive, then datagrams that end inside the receiving channel.
    add_fill(4, 8'hff);
    send_dgram();
    dgram.delete();
    add_fill(2, 8'h00);
    send_dgram();
    dgram.delete();
    add_fill(1, 8'hff);
    send_dgram();

    // Every handshake option, the addressing method kept across options,
    // zero-length lists, unknown codes, unknown types, then a data body.
    dgram.delete();
    add_bytes(4);
    add_message(psdp_pkg::MsgHandshake, 0, to_end);
    add_opt_byte(psdp_pkg::OptAddrMethod, AddrBins32);
    add_opt_fixed(psdp_pkg::OptLiveWindow, 4);
    add_opt_byte(psdp_pkg::OptAddrMethod, 8'd3);
    add_opt_fixed(psdp_pkg::OptChunkSize, 4);
    add_opt_fixed(psdp_pkg::OptLiveWindow, 8);
    add_opt_list(psdp_pkg::OptSwarmId, 16'd0);
    add_opt_list(psdp_pkg::OptSuppMsgs, 16'd0);
    add_opt_fixed(OptUnknownLo, 0);
    add_opt_fixed(OptUnknownHi, 0);
    add_opt_byte(OptVersion, 8'hff);
    add_opt_byte(OptMinVersion, 8'h00);
    add_opt_byte(OptIntegrity, 8'h5a);
    add_opt_byte(OptSigAlgo, 8'ha5);
    add_opt_byte(OptMerkleFn, 8'h01);
    add_opt_list(psdp_pkg::OptSwarmId, 16'd3);
    add_opt_list(psdp_pkg::OptSuppMsgs, 16'd2);
    dgram.push_back(psdp_pkg::OptEnd);
    add_message(MsgUnknownHi, 0, to_end);
    add_message(MsgPexReq, 0, to_end);
    add_message(MsgChoke, 0, to_end);
    add_message(MsgUnchoke, 0, to_end);
    add_message(MsgData, 5, to_end);
    send_dgram();

    // All fixed-layout types back to back, closed by a certificate.
    dgram.delete();
    add_bytes(4);
    add_message(MsgAck, 0, to_end);
    add_message(MsgHave, 0, to_end);
    add_message(MsgIntegrity, 0, to_end);
    add_message(MsgPexV4, 0, to_end);
    add_message(MsgRequest, 0, to_end);
    add_message(MsgCancel, 0, to_end);
    add_message(MsgPexV6, 0, to_end);
    add_message(MsgPexCert, 3, to_end);
    send_dgram();

    // Signed integrity whose body is empty: not truncated.
    dgram.delete();
    add_bytes(4);
    add_message(MsgSigned, 0, to_end);
    send_dgram();

    // Ends right after an option code, then inside a hash field.
    dgram.delete();
    add_bytes(4);
    add_message(psdp_pkg::MsgHandshake, 0, to_end);
    dgram.push_back(psdp_pkg::OptLiveWindow);
    send_dgram();
    dgram.delete();
    add_bytes(4);
    dgram.push_back(MsgIntegrity);
    add_bytes(10);
    send_dgram();

    // A new handshake restores the default addressing method.
    dgram.delete();
    add_bytes(4);
    add_message(psdp_pkg::MsgHandshake, 0, to_end);
    add_opt_byte(psdp_pkg::OptAddrMethod, 8'd1);
    dgram.push_back(psdp_pkg::OptEnd);
    add_message(psdp_pkg::MsgHandshake, 0, to_end);
    add_opt_fixed(psdp_pkg::OptLiveWindow, 4);
    dgram.push_back(psdp_pkg::OptEnd);
    send_dgram();

    // Random datagrams: an idle-free stretch first, then one long output
    // hold-off and one full drain along the way.
    base = sb.requests;
    while (sb.requests - base < 1350) begin
      steady = (sb.requests - base < 300);
      if (!held && sb.requests - base > 600) begin
        held = 1'b1;
        holds_asked++;
      end
      if (!drained && sb.requests - base > 1000) begin
        drained = 1'b1;
        drain();
      end
      build_random_dgram();
      send_dgram();
    end
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d datagrams (%0d bytes); checked %0d results, including %0d truncated",
             sb.datagrams, sb.requests, sb.results, sb.ends_truncated);
    $display("and %0d keep-alive endings; %0d mismatches.", sb.ends_keep_alive, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
